@@ design/tet_pkg.sv @@
// ----------------------------------------------------------------------------
// tet_pkg: shared types and constants for the timed event table
// Result layout, result kinds and the command/status groups that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package tet_pkg;

  localparam int unsigned EntriesDef  = 16;
  localparam int unsigned TimeBitsDef = 24;
  localparam int unsigned MaxResults  = 16;
  localparam int unsigned ResCntW     = $clog2(MaxResults + 1);

  typedef enum logic [1:0] {
    KIND_ADD_OK   = 2'd0,
    KIND_ADD_FULL = 2'd1,
    KIND_REPORT   = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  slot;
    logic [7:0]  tag;
    logic        started;
    logic        updated;
    logic [23:0] elapsed;
    logic        ended;
    logic        removed;
    logic        last;
  } result_t;

  typedef struct packed {
    logic capture;
    logic add_commit;
    logic walk_start;
    logic walk_step;
    logic flush;
    logic cmp_start;
    logic cmp_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic tbl_empty;
    logic out_free;
    logic step_stall;
    logic idx_zero;
    logic flush_ok;
    logic any_removed;
    logic cmp_empty;
    logic cmp_last;
  } dp_status_t;

endpackage

@@ design/tet_ctrl.sv @@
// ----------------------------------------------------------------------------
// tet_ctrl: sequencer of the timed event table
// Steps the datapath through an add, a downward tick walk, the final flush
// of the held report and the compaction pass after removals.
// ----------------------------------------------------------------------------
module tet_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               action_i,
  input  tet_pkg::dp_status_t status_i,
  output logic               in_ready_o,
  output tet_pkg::ctrl_cmd_t cmd_o
);
  import tet_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_ADD   = 7'b0000010,
    ST_WRD   = 7'b0000100,
    ST_WEX   = 7'b0001000,
    ST_FLUSH = 7'b0010000,
    ST_CRD   = 7'b0100000,
    ST_CMV   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (action_i) begin
            state_d = ST_ADD;
          end else if (!status_i.tbl_empty) begin
            state_d = ST_WRD;
          end
        end
      end
      ST_ADD: begin
        if (status_i.out_free) begin
          cmd_o.add_commit = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_WRD: begin
        cmd_o.walk_start = 1'b1;
        state_d          = ST_WEX;
      end
      ST_WEX: begin
        if (!status_i.step_stall) begin
          cmd_o.walk_step = 1'b1;
          if (status_i.idx_zero) begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (status_i.flush_ok) begin
          cmd_o.flush = 1'b1;
          state_d     = status_i.any_removed ? ST_CRD : ST_IDLE;
        end
      end
      ST_CRD: begin
        cmd_o.cmp_start = 1'b1;
        state_d         = status_i.cmp_empty ? ST_IDLE : ST_CMV;
      end
      ST_CMV: begin
        cmd_o.cmp_step = 1'b1;
        if (status_i.cmp_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/tet_dp.sv @@
// ----------------------------------------------------------------------------
// tet_dp: datapath of the timed event table
// Entry memory, entry count, per-entry tick update, report buffering and
// the compaction pointers.
// ----------------------------------------------------------------------------
module tet_dp #(
  parameter int unsigned Entries  = tet_pkg::EntriesDef,
  parameter int unsigned TimeBits = tet_pkg::TimeBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tet_pkg::ctrl_cmd_t  cmd_i,
  output tet_pkg::dp_status_t status_o,
  input  logic [15:0]         delta_time_i,
  input  logic [23:0]         start_delay_i,
  input  logic [23:0]         loop_length_i,
  input  logic                repeat_req_i,
  input  logic                tracks_progress_i,
  input  logic [7:0]          tag_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tet_pkg::result_t    out_res_o
);
  import tet_pkg::*;

  localparam int unsigned IW = $clog2(Entries);
  localparam int unsigned CW = $clog2(Entries + 1);
  localparam int unsigned TW = TimeBits;
  localparam int unsigned SW = ((TW > 16) ? TW : 16) + 1;
  localparam int unsigned WB = (TW > 24) ? TW : 24;
  localparam logic [TW-1:0] TMax = '1;

  typedef struct packed {
    logic [TW-1:0] delay;
    logic [TW-1:0] limit;
    logic [TW-1:0] elapsed;
    logic          started;
    logic          rep_mode;
    logic          prog_mode;
    logic [7:0]    tag;
  } entry_t;

  function automatic logic [TW-1:0] sat_in(logic [23:0] v);
    logic [WB-1:0] x;
    x = WB'(v);
    return (x > WB'(TMax)) ? TMax : x[TW-1:0];
  endfunction

  // Entry memory: one write and one registered read per cycle.
  entry_t        mem_q [Entries];
  entry_t        rdata_q;
  logic          rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;
  entry_t        wr_data;

  // Captured item.
  logic [15:0]   dt_q;
  logic [23:0]   sd_q, ll_q;
  logic          rep_q, prog_q;
  logic [7:0]    tag_q;

  logic [CW-1:0] count_q;
  logic [IW-1:0] idx_q;
  logic [Entries-1:0] rm_q;
  logic          any_rm_q;
  logic [IW-1:0] low_q;
  logic [CW-1:0] rd_q, wr_q;
  logic [ResCntW-1:0] n_q;
  result_t       pend_q;
  logic          pend_v_q;
  result_t       out_q;
  logic          out_v_q;

  logic          out_free;
  logic          full;
  logic [CW-1:0] cnt_m1, lowp1, rdp1;
  logic          keep;

  // Tick update of the entry under the walk.
  logic [SW-1:0] dly_x, dt_x, dly_sub, el_sum;
  logic [TW-1:0] dly_new, el_new;
  logic          st, up, en, rm, restart, has_rep;
  logic [WB-1:0] el_wide;
  logic [23:0]   el_rep;
  logic [IW+3:0] idx_x;
  logic [CW+3:0] cnt_x;
  entry_t        wb_entry, add_entry;
  result_t       rep_res, add_res;

  assign out_free = !out_v_q || out_ready_i;
  assign full     = (count_q == CW'(Entries));
  assign cnt_m1   = count_q - CW'(1);
  assign lowp1    = CW'(low_q) + CW'(1);
  assign rdp1     = rd_q + CW'(1);
  assign keep     = !rm_q[rd_q[IW-1:0]];

  always_comb begin
    dly_x   = SW'(rdata_q.delay);
    dt_x    = SW'(dt_q);
    dly_sub = dly_x - dt_x;
    dly_new = (dly_x > dt_x) ? dly_sub[TW-1:0] : '0;
    el_sum  = SW'(rdata_q.elapsed) + dt_x;
    el_new  = (el_sum > SW'(TMax)) ? TMax : el_sum[TW-1:0];
    st      = (dly_new == '0) && !rdata_q.started;
    up      = rdata_q.prog_mode;
    en      = rdata_q.prog_mode && (rdata_q.limit < el_new);
    rm      = en && !rdata_q.rep_mode;
    restart = en && rdata_q.rep_mode;
    has_rep = (st || up || en) && (n_q < ResCntW'(MaxResults));

    el_wide = WB'(el_new);
    el_rep  = '0;
    if (up) begin
      el_rep = (el_wide > WB'(24'hFFFFFF)) ? 24'hFFFFFF : el_wide[23:0];
    end

    wb_entry         = rdata_q;
    wb_entry.delay   = restart ? '0 : dly_new;
    wb_entry.elapsed = restart ? '0 : el_new;
    wb_entry.started = restart ? 1'b0 : (rdata_q.started || st);

    idx_x           = (IW + 4)'(idx_q);
    rep_res.kind    = KIND_REPORT;
    rep_res.slot    = idx_x[3:0];
    rep_res.tag     = rdata_q.tag;
    rep_res.started = st;
    rep_res.updated = up;
    rep_res.elapsed = el_rep;
    rep_res.ended   = en;
    rep_res.removed = rm;
    rep_res.last    = 1'b0;

    add_entry.delay     = sat_in(sd_q);
    add_entry.limit     = sat_in(ll_q);
    add_entry.elapsed   = '0;
    add_entry.started   = 1'b0;
    add_entry.rep_mode  = rep_q;
    add_entry.prog_mode = prog_q;
    add_entry.tag       = tag_q;

    cnt_x   = (CW + 4)'(count_q);
    add_res = '0;
    add_res.kind = full ? KIND_ADD_FULL : KIND_ADD_OK;
    add_res.slot = full ? 4'd0 : cnt_x[3:0];
    add_res.tag  = tag_q;
    add_res.last = 1'b1;
  end

  // Memory port steering.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_q;
    wr_en   = 1'b0;
    wr_addr = idx_q;
    wr_data = wb_entry;
    if (cmd_i.add_commit) begin
      wr_en   = !full;
      wr_addr = count_q[IW-1:0];
      wr_data = add_entry;
    end
    if (cmd_i.walk_start) begin
      rd_en = 1'b1;
    end
    if (cmd_i.walk_step) begin
      wr_en   = 1'b1;
      rd_en   = 1'b1;
      rd_addr = idx_q - IW'(1);
    end
    if (cmd_i.cmp_start) begin
      rd_en   = 1'b1;
      rd_addr = lowp1[IW-1:0];
    end
    if (cmd_i.cmp_step) begin
      wr_en   = keep;
      wr_addr = wr_q[IW-1:0];
      wr_data = rdata_q;
      rd_en   = 1'b1;
      rd_addr = rdp1[IW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      dt_q   <= delta_time_i;
      sd_q   <= start_delay_i;
      ll_q   <= loop_length_i;
      rep_q  <= repeat_req_i;
      prog_q <= tracks_progress_i;
      tag_q  <= tag_i;
    end
    if (cmd_i.walk_step && has_rep) begin
      pend_q <= rep_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      idx_q    <= '0;
      rm_q     <= '0;
      any_rm_q <= 1'b0;
      low_q    <= '0;
      rd_q     <= '0;
      wr_q     <= '0;
      n_q      <= '0;
      pend_v_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        idx_q <= cnt_m1[IW-1:0];
      end
      if (cmd_i.add_commit && !full) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.walk_start) begin
        rm_q     <= '0;
        any_rm_q <= 1'b0;
        n_q      <= '0;
        pend_v_q <= 1'b0;
      end
      if (cmd_i.walk_step) begin
        idx_q <= idx_q - IW'(1);
        if (rm) begin
          rm_q[idx_q] <= 1'b1;
          any_rm_q    <= 1'b1;
          low_q       <= idx_q;
        end
        if (has_rep) begin
          n_q      <= n_q + ResCntW'(1);
          pend_v_q <= 1'b1;
        end
      end
      if (cmd_i.flush) begin
        pend_v_q <= 1'b0;
      end
      if (cmd_i.cmp_start) begin
        rd_q <= lowp1;
        wr_q <= CW'(low_q);
        if (lowp1 == count_q) begin
          count_q <= CW'(low_q);
        end
      end
      if (cmd_i.cmp_step) begin
        rd_q <= rdp1;
        wr_q <= wr_q + CW'(keep);
        if (rdp1 == count_q) begin
          count_q <= wr_q + CW'(keep);
        end
      end
    end
  end

  // Output register. A walk report is held back until the next report or the
  // end of the walk shows whether it is the final one.
  logic    out_load;
  result_t out_next;

  always_comb begin
    out_load = 1'b0;
    out_next = pend_q;
    if (cmd_i.add_commit) begin
      out_load = 1'b1;
      out_next = add_res;
    end else if (cmd_i.walk_step && has_rep && pend_v_q) begin
      out_load = 1'b1;
    end else if (cmd_i.flush && pend_v_q) begin
      out_load      = 1'b1;
      out_next.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_load) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_res_o   = out_q;

  assign status_o.tbl_empty   = (count_q == '0);
  assign status_o.out_free    = out_free;
  assign status_o.step_stall  = has_rep && pend_v_q && !out_free;
  assign status_o.idx_zero    = (idx_q == '0);
  assign status_o.flush_ok    = !pend_v_q || out_free;
  assign status_o.any_removed = any_rm_q;
  assign status_o.cmp_empty   = (lowp1 == count_q);
  assign status_o.cmp_last    = (rdp1 == count_q);

endmodule

@@ design/timed_event_table.sv @@
// ----------------------------------------------------------------------------
// timed_event_table: table of timed events driven by add and tick items
// An add is captured in idle and committed in the add state once the output
// register is free, which registers its result; input is not ready meanwhile.
// A tick reads the top entry, walks down the entries and flushes the held
// report (an empty table ends it at once); a removal adds a compaction pass.
// Results stream out during the walk. One item is handled at a time; the
// walk reads and writes one entry per cycle unless a stalled result holds it.
// Reset empties the table and idles the sequencer; entry storage is not cleared.
// ----------------------------------------------------------------------------
module timed_event_table #(
  parameter int unsigned Entries  = tet_pkg::EntriesDef,
  parameter int unsigned TimeBits = tet_pkg::TimeBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [15:0] delta_time_i,
  input  logic [23:0] start_delay_i,
  input  logic [23:0] loop_length_i,
  input  logic        repeat_req_i,
  input  logic        tracks_progress_i,
  input  logic [7:0]  tag_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [3:0]  slot_o,
  output logic [7:0]  entry_tag_o,
  output logic        started_o,
  output logic        updated_o,
  output logic [23:0] elapsed_o,
  output logic        ended_o,
  output logic        removed_o,
  output logic        last_o
);
  import tet_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  result_t    res;

  tet_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  tet_dp #(
    .Entries  (Entries),
    .TimeBits (TimeBits)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .delta_time_i      (delta_time_i),
    .start_delay_i     (start_delay_i),
    .loop_length_i     (loop_length_i),
    .repeat_req_i      (repeat_req_i),
    .tracks_progress_i (tracks_progress_i),
    .tag_i             (tag_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_res_o         (res)
  );

  assign kind_o      = res.kind;
  assign slot_o      = res.slot;
  assign entry_tag_o = res.tag;
  assign started_o   = res.started;
  assign updated_o   = res.updated;
  assign elapsed_o   = res.elapsed;
  assign ended_o     = res.ended;
  assign removed_o   = res.removed;
  assign last_o      = res.last;

endmodule

@@ design/tet_checker.sv @@
// ----------------------------------------------------------------------------
// tet_checker: port-level checks for the timed event table
// Watches the result channel and is bound to every instance of the top level.
// ----------------------------------------------------------------------------
module tet_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  kind_o,
  input logic [3:0]  slot_o,
  input logic [7:0]  entry_tag_o,
  input logic        started_o,
  input logic        updated_o,
  input logic [23:0] elapsed_o,
  input logic        ended_o,
  input logic        removed_o,
  input logic        last_o
);
  import tet_pkg::*;

  // A stalled result stays valid and holds its kind, slot, tag, elapsed time and last flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) &&
    $stable(slot_o) && $stable(entry_tag_o) && $stable(elapsed_o) && $stable(last_o))
    else $error("result changed while stalled");

  // An add gives exactly one result, so it always closes its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != KIND_REPORT) |-> last_o &&
    !started_o && !updated_o && !ended_o && !removed_o && (elapsed_o == 24'd0))
    else $error("add result malformed");

  // Every report carries at least one event.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_REPORT) |-> started_o || updated_o || ended_o)
    else $error("empty report");

  // Only a progress entry can end, and only an ended entry is removed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (removed_o || ended_o) |-> updated_o && (ended_o || !removed_o))
    else $error("end or removal without progress");

  // Elapsed time is shown only together with a progress report.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !updated_o |-> (elapsed_o == 24'd0))
    else $error("elapsed set without update");

endmodule

bind timed_event_table tet_checker u_tet_checker (.*);

@@ tb/sv/timed_event_table_checker.sv @@
// ----------------------------------------------------------------------------
// timed_event_table_checker: result prediction and checking for the event table
// Keeps its own copy of the event table, updated from every accepted input
// item, and compares each accepted result item field by field with the
// oldest predicted one.
// ----------------------------------------------------------------------------
module timed_event_table_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        action_i,
  input  logic [15:0] delta_time_i,
  input  logic [23:0] start_delay_i,
  input  logic [23:0] loop_length_i,
  input  logic        repeat_req_i,
  input  logic        tracks_progress_i,
  input  logic [7:0]  tag_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  kind_i,
  input  logic [3:0]  slot_i,
  input  logic [7:0]  entry_tag_i,
  input  logic        started_i,
  input  logic        updated_i,
  input  logic [23:0] elapsed_i,
  input  logic        ended_i,
  input  logic        removed_i,
  input  logic        last_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import tet_pkg::*;

  localparam logic        ActAdd = 1'b1;
  localparam int unsigned Slots  = EntriesDef;

  logic [4:0]  live_entries;
  logic [23:0] delay_left [Slots];
  logic [23:0] loop_limit [Slots];
  logic [23:0] elapsed_now [Slots];
  logic        start_done [Slots];
  logic        repeat_mode [Slots];
  logic        progress_mode [Slots];
  logic [7:0]  entry_tag [Slots];

  result_t     reports_due [$];
  result_t     oldest;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    live_entries = '0;
  end

  function automatic void table_add(logic [23:0] delay, logic [23:0] limit, logic rep,
                                    logic prog, logic [7:0] tag);
    result_t ack;
    ack      = '0;
    ack.tag  = tag;
    ack.last = 1'b1;
    if (live_entries < Slots) begin
      ack.kind                    = KIND_ADD_OK;
      ack.slot                    = live_entries[3:0];
      delay_left[live_entries]    = delay;
      loop_limit[live_entries]    = limit;
      elapsed_now[live_entries]   = '0;
      start_done[live_entries]    = 1'b0;
      repeat_mode[live_entries]   = rep;
      progress_mode[live_entries] = prog;
      entry_tag[live_entries]     = tag;
      live_entries++;
    end else begin
      ack.kind = KIND_ADD_FULL;
    end
    reports_due.push_back(ack);
  endfunction

  // Walks the table from the top slot down. Each report is held back one
  // step so that the final one of the tick can be marked as last.
  function automatic void table_tick(logic [15:0] dt);
    result_t     rpt;
    result_t     held;
    logic        have_held;
    logic [24:0] sum;
    int          made;
    held      = '0;
    have_held = 1'b0;
    made      = 0;
    for (int i = int'(live_entries) - 1; i >= 0; i--) begin
      rpt      = '0;
      rpt.kind = KIND_REPORT;
      rpt.slot = 4'(i);
      rpt.tag  = entry_tag[i];
      delay_left[i] = (delay_left[i] > 24'(dt)) ? delay_left[i] - 24'(dt) : 24'd0;
      if (delay_left[i] == 24'd0 && !start_done[i]) begin
        rpt.started   = 1'b1;
        start_done[i] = 1'b1;
      end
      sum            = {1'b0, elapsed_now[i]} + 25'(dt);
      elapsed_now[i] = sum[24] ? 24'hFFFFFF : sum[23:0];
      if (progress_mode[i]) begin
        rpt.updated = 1'b1;
        rpt.elapsed = elapsed_now[i];
        if (loop_limit[i] < elapsed_now[i]) begin
          rpt.ended = 1'b1;
          if (!repeat_mode[i]) begin
            rpt.removed = 1'b1;
            for (int j = i; j + 1 < int'(live_entries); j++) begin
              delay_left[j]    = delay_left[j + 1];
              loop_limit[j]    = loop_limit[j + 1];
              elapsed_now[j]   = elapsed_now[j + 1];
              start_done[j]    = start_done[j + 1];
              repeat_mode[j]   = repeat_mode[j + 1];
              progress_mode[j] = progress_mode[j + 1];
              entry_tag[j]     = entry_tag[j + 1];
            end
            live_entries--;
          end else begin
            delay_left[i]  = '0;
            elapsed_now[i] = '0;
            start_done[i]  = 1'b0;
          end
        end
      end
      if ((rpt.started || rpt.updated || rpt.ended) && made < MaxResults) begin
        if (have_held) begin
          reports_due.push_back(held);
        end
        held      = rpt;
        have_held = 1'b1;
        made++;
      end
    end
    if (have_held) begin
      held.last = 1'b1;
      reports_due.push_back(held);
    end
  endfunction

  function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_entries = '0;
      reports_due.delete();
      pending_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        if (action_i == ActAdd) begin
          table_add(start_delay_i, loop_length_i, repeat_req_i, tracks_progress_i, tag_i);
        end else begin
          table_tick(delta_time_i);
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (reports_due.size() == 0) begin
          $display("%0t ns: unexpected result item: expected none, got kind %0d slot %0d tag %0h",
                   $time, kind_i, slot_i, entry_tag_i);
          fail_count_o++;
        end else begin
          oldest = reports_due.pop_front();
          check_field("kind", oldest.kind, kind_i);
          check_field("slot", oldest.slot, slot_i);
          check_field("entry_tag", oldest.tag, entry_tag_i);
          check_field("started", oldest.started, started_i);
          check_field("updated", oldest.updated, updated_i);
          check_field("elapsed", oldest.elapsed, elapsed_i);
          check_field("ended", oldest.ended, ended_i);
          check_field("removed", oldest.removed, removed_i);
          check_field("last", oldest.last, last_i);
        end
      end
      pending_o <= reports_due.size();
    end
  end

endmodule

@@ tb/sv/tb_timed_event_table.sv @@
// ----------------------------------------------------------------------------
// tb_timed_event_table: stimulus and verdict for the timed event table
// Fills and overfills the table, runs ticks over the extremes of the time
// fields, then random add and tick items under changing back-pressure, and
// finally drives elapsed times into saturation.
// ----------------------------------------------------------------------------
module tb_timed_event_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic ActTick = 1'b0;
  localparam logic ActAdd  = 1'b1;

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_ready;
  logic        action          = 1'b0;
  logic [15:0] delta_time      = '0;
  logic [23:0] start_delay     = '0;
  logic [23:0] loop_length     = '0;
  logic        repeat_req      = 1'b0;
  logic        tracks_progress = 1'b0;
  logic [7:0]  tag             = '0;
  logic        out_valid;
  logic        out_ready       = 1'b0;
  logic [1:0]  kind;
  logic [3:0]  slot;
  logic [7:0]  entry_tag;
  logic        started;
  logic        updated;
  logic [23:0] elapsed;
  logic        ended;
  logic        removed;
  logic        last;

  int unsigned in_idle_pct  = 0;
  int unsigned out_idle_pct = 0;
  // Entries that may stay for good; kept few so the table keeps churning.
  int unsigned keepers_left = 3;
  int unsigned fail_count;
  int unsigned pending;

  always #6 clk = ~clk;

  timed_event_table u_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .action_i          (action),
    .delta_time_i      (delta_time),
    .start_delay_i     (start_delay),
    .loop_length_i     (loop_length),
    .repeat_req_i      (repeat_req),
    .tracks_progress_i (tracks_progress),
    .tag_i             (tag),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .kind_o            (kind),
    .slot_o            (slot),
    .entry_tag_o       (entry_tag),
    .started_o         (started),
    .updated_o         (updated),
    .elapsed_o         (elapsed),
    .ended_o           (ended),
    .removed_o         (removed),
    .last_o            (last)
  );

  timed_event_table_checker u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .action_i          (action),
    .delta_time_i      (delta_time),
    .start_delay_i     (start_delay),
    .loop_length_i     (loop_length),
    .repeat_req_i      (repeat_req),
    .tracks_progress_i (tracks_progress),
    .tag_i             (tag),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .kind_i            (kind),
    .slot_i            (slot),
    .entry_tag_i       (entry_tag),
    .started_i         (started),
    .updated_i         (updated),
    .elapsed_i         (elapsed),
    .ended_i           (ended),
    .removed_i         (removed),
    .last_i            (last),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  // Valid is only lowered on an idle cycle, so back-to-back items keep it high.
  task automatic send_item(logic act, logic [15:0] dt, logic [23:0] delay,
                           logic [23:0] limit, logic rep, logic prog, logic [7:0] id);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    action          <= act;
    delta_time      <= dt;
    start_delay     <= delay;
    loop_length     <= limit;
    repeat_req      <= rep;
    tracks_progress <= prog;
    tag             <= id;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_add(logic [23:0] delay, logic [23:0] limit, logic rep, logic prog,
                          logic [7:0] id);
    send_item(ActAdd, 16'($urandom), delay, limit, rep, prog, id);
  endtask

  task automatic send_tick(logic [15:0] dt);
    send_item(ActTick, dt, 24'($urandom), 24'($urandom), 1'($urandom), 1'($urandom),
              8'($urandom));
  endtask

  function automatic logic [23:0] pick_delay();
    case ($urandom_range(9))
      0:       return 24'd0;
      1:       return 24'($urandom);
      2:       return 24'hFFFFFF;
      default: return 24'($urandom_range(200));
    endcase
  endfunction

  function automatic logic [15:0] pick_step();
    case ($urandom_range(19))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom);
      default: return 16'($urandom_range(150));
    endcase
  endfunction

  task automatic send_random_item();
    if ($urandom_range(99) < 45) begin
      if (keepers_left > 0 && $urandom_range(14) == 0) begin
        keepers_left--;
        send_add(pick_delay(), 24'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
      end else begin
        send_add(pick_delay(), 24'($urandom_range(600)), 1'b0, 1'b1, 8'($urandom));
      end
    end else begin
      send_tick(pick_step());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_idle_pct  = 33;
    out_idle_pct = 65;

    send_tick(16'd1);
    // Long-lived entries: a silent one that starts at once, one that starts
    // only after a very long delay, and two repeating progress entries.
    send_add(24'd0, 24'd0, 1'b0, 1'b0, 8'h00);
    send_add(24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b0, 8'hFF);
    send_add(24'd5, 24'd0, 1'b1, 1'b1, 8'h5A);
    send_add(24'd0, 24'd1000, 1'b1, 1'b1, 8'hA5);
    for (int k = 4; k < 16; k++) begin
      send_add(24'(k * 3), (k % 3 == 0) ? 24'd0 : (k % 3 == 1) ? 24'hFFFF : 24'(k * 100),
               1'b0, 1'b1, 8'(k * 17));
    end
    send_add(24'd7, 24'd7, 1'b0, 1'b1, 8'h3C);
    // A zero step must not end an entry whose loop length is zero.
    send_tick(16'd0);
    send_tick(16'hFFFF);
    send_tick(16'd1);
    send_tick(16'hFFFF);

    repeat (6) send_random_item();

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);

    in_idle_pct  = 65;
    out_idle_pct = 33;
    repeat (6) send_random_item();

    // Clear out short-lived entries, then run elapsed times into saturation.
    // Both new entries end on the 257th full step.
    repeat (3) send_tick(16'hFFFF);
    send_add(24'd0, 24'hFFFFFE, 1'b1, 1'b1, 8'h81);
    send_add(24'd3, 24'hFFFFFE, 1'b0, 1'b1, 8'h7E);
    repeat (128) send_tick(16'hFFFF);

    in_idle_pct  = 0;
    out_idle_pct = 0;
    repeat (129) send_tick(16'hFFFF);

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (40) @(posedge clk);

    if (fail_count == 0) begin
      $display("timed_event_table test passed");
    end else begin
      $display("timed_event_table test failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timed_event_table test failed");
    $finish;
  end

endmodule
